>>> hw/rtl/wfe_pkg.sv
// Shared types, constants and helper functions for the waveform feature extractor.
// Depends on nothing; wfe_channels, wfe_front, wfe_back and the top level import it.
`default_nettype none

package wfe_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int ADC_BITS_DEF    = 14;

   // Fixed widths of the register file and of the result fields.
   localparam int CFG_W      = 11;
   localparam int MV_W       = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int OUT_W      = 32;
   localparam int PEAK_W     = 10;

   // 1000 mV in Q15.16.
   localparam int OFFSET_Q16 = 65536000;

   // Register reset values.
   localparam logic [MV_W-1:0]  MV_PER_CODE_RST = 16'd8000;
   localparam logic             NEG_POL_RST     = 1'b1;
   localparam logic [CFG_W-1:0] NUM_SAMPLES_RST = 11'd1024;
   localparam logic [CFG_W-1:0] BASELINE_RST    = 11'd15;
   localparam logic [CFG_W-1:0] GUARD_RST       = 11'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MV_PER_CODE = 3'd0,
      CSR_NEG_POL     = 3'd1,
      CSR_NUM_SAMPLES = 3'd2,
      CSR_BASELINE    = 3'd3,
      CSR_GUARD       = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_LAUNCH,
      BK_DIV,
      BK_FIN
   } back_state_type;

   // How the front end classified one sample.
   typedef struct packed {
      logic last;
      logic in_start;
      logic in_end;
   } item_flags_type;

   typedef struct packed {
      logic [OUT_W-1:0]  wave_mv;
      logic              waveform_end;
      logic [OUT_W-1:0]  min_mv;
      logic [OUT_W-1:0]  max_mv;
      logic [OUT_W-1:0]  peak_to_peak_mv;
      logic [OUT_W-1:0]  mean_mv;
      logic [PEAK_W-1:0] peak_index;
      logic [OUT_W-1:0]  baseline_mv;
      logic [OUT_W-1:0]  max_above_base;
      logic [OUT_W-1:0]  min_above_base;
   } rsp_payload_type;

   // Converted sample: wide enough for the product and for the 1000 mV offset.
   function automatic int value_width(input int adc_bits);
      int w;
      w = (adc_bits + MV_W > 26) ? adc_bits + MV_W : 26;
      return w + 1;
   endfunction

   function automatic int index_width(input int max_samples);
      return $clog2(max_samples);
   endfunction

   function automatic int count_width(input int max_samples);
      return $clog2(max_samples) + 1;
   endfunction

   function automatic int sum_width(input int adc_bits, input int max_samples);
      return value_width(adc_bits) + $clog2(max_samples);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wfe_channels.sv
// Valid/ready channel interfaces for ADC samples and for result items.
// Depends on wfe_pkg for default widths.
`default_nettype none

interface wfe_req_if import wfe_pkg::*; #(parameter int ADC_W = ADC_BITS_DEF);
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface wfe_rsp_if import wfe_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  wave_mv;
   logic                     waveform_end;
   logic signed [OUT_W-1:0]  min_mv;
   logic signed [OUT_W-1:0]  max_mv;
   logic signed [OUT_W-1:0]  peak_to_peak_mv;
   logic signed [OUT_W-1:0]  mean_mv;
   logic        [PEAK_W-1:0] peak_index;
   logic signed [OUT_W-1:0]  baseline_mv;
   logic signed [OUT_W-1:0]  max_above_base;
   logic signed [OUT_W-1:0]  min_above_base;

   modport source (output valid, output wave_mv, output waveform_end, output min_mv,
                   output max_mv, output peak_to_peak_mv, output mean_mv,
                   output peak_index, output baseline_mv, output max_above_base,
                   output min_above_base, input ready);
   modport sink   (input valid, input wave_mv, input waveform_end, input min_mv,
                   input max_mv, input peak_to_peak_mv, input mean_mv,
                   input peak_index, input baseline_mv, input max_above_base,
                   input min_above_base, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wfe_fifo.sv
// Small register queue between the front end and the back end.
// Depends on nothing beyond its parameters.
`default_nettype none

module wfe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wfe_divider.sv
// Radix-2 restoring divider, signed dividend by positive divisor, truncating toward zero.
// Depends on nothing beyond its parameters; one quotient bit per cycle.
`default_nettype none

module wfe_divider #(
   parameter int DIVIDEND_W = 41,
   parameter int DIVISOR_W  = 11
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DIVIDEND_W-1:0] dividend,
   input  wire logic        [DIVISOR_W-1:0]  divisor,
   output logic                              done,
   output logic signed [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         neg_in  = dividend[DIVIDEND_W-1];
         quot_in = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quot_ff) : $signed(quot_ff);

endmodule

`default_nettype wire

>>> hw/rtl/wfe_front.sv
// Front end: accepts ADC codes, scales them and tags each with its index and window flags.
// Depends on wfe_pkg and wfe_channels; feeds wfe_fifo.
`default_nettype none

module wfe_front import wfe_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int ADC_BITS    = ADC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   wfe_req_if.sink                                    req_chan,
   input  wire logic [MV_W-1:0]                       mv_per_code,
   input  wire logic                                  negative_polarity,
   input  wire logic [count_width(MAX_SAMPLES)-1:0]   n_eff,
   input  wire logic [count_width(MAX_SAMPLES)-1:0]   b_eff,
   input  wire logic                                  fifo_full,
   output logic                                       push,
   output logic [value_width(ADC_BITS) + index_width(MAX_SAMPLES)
                 + $bits(item_flags_type) - 1:0]      push_data
);

   localparam int V_W    = value_width(ADC_BITS);
   localparam int IDX_W  = index_width(MAX_SAMPLES);
   localparam int NW     = count_width(MAX_SAMPLES);
   localparam int PROD_W = ADC_BITS + MV_W;

   logic                    accept;
   logic                    req_ready;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    stage_valid_ff, stage_valid_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [IDX_W-1:0]        idx_ff;
   item_flags_type          flags_ff;
   item_flags_type          flags_now;
   logic signed [V_W-1:0]   shifted;
   logic signed [V_W-1:0]   value;

   assign req_ready      = !stage_valid_ff || !fifo_full;
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;
   assign push           = stage_valid_ff;

   // Window membership and end of waveform for the sample being accepted.
   always_comb begin
      flags_now.last     = ((NW'(cnt_ff) + NW'(1)) >= n_eff);
      flags_now.in_start = (NW'(cnt_ff) < b_eff);
      flags_now.in_end   = (NW'(cnt_ff) >= (n_eff - b_eff));
   end

   always_comb begin
      cnt_in         = cnt_ff;
      stage_valid_in = stage_valid_ff;
      if (push && !fifo_full) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         cnt_in         = flags_now.last ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         cnt_ff         <= cnt_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff  <= PROD_W'(req_chan.adc_code) * PROD_W'(mv_per_code);
         idx_ff   <= cnt_ff;
         flags_ff <= flags_now;
      end
   end

   // Offset by 1000 mV, then flip for negative pulses.
   assign shifted   = $signed(V_W'(prod_ff)) - V_W'(OFFSET_Q16);
   assign value     = negative_polarity ? -shifted : shifted;
   assign push_data = {value, idx_ff, flags_ff};

endmodule

`default_nettype wire

>>> hw/rtl/wfe_back.sv
// Back end: running min, max and window sums, end-of-waveform divisions and the result register.
// Depends on wfe_pkg, wfe_channels and wfe_divider; reads wfe_fifo.
`default_nettype none

module wfe_back import wfe_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int ADC_BITS    = ADC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [value_width(ADC_BITS) + index_width(MAX_SAMPLES)
                      + $bits(item_flags_type) - 1:0] head_data,
   input  wire logic                                  fifo_empty,
   output logic                                       pop,
   input  wire logic [count_width(MAX_SAMPLES)-1:0]   n_eff,
   input  wire logic [count_width(MAX_SAMPLES)-1:0]   b_eff,
   input  wire logic [CFG_W-1:0]                      guard_samples,
   wfe_rsp_if.source                                  rsp_chan
);

   localparam int V_W   = value_width(ADC_BITS);
   localparam int IDX_W = index_width(MAX_SAMPLES);
   localparam int NW    = count_width(MAX_SAMPLES);
   localparam int SUM_W = sum_width(ADC_BITS, MAX_SAMPLES);

   localparam logic signed [V_W-1:0] MIN_RST = V_W'(OFFSET_Q16);
   localparam logic signed [V_W-1:0] MAX_RST = -V_W'(OFFSET_Q16);

   back_state_type          state_ff, state_in;

   logic signed [V_W-1:0]   head_v;
   logic [IDX_W-1:0]        head_idx;
   item_flags_type          head_flags;

   logic signed [V_W-1:0]   min_ff, min_in;
   logic signed [V_W-1:0]   max_ff, max_in;
   logic [IDX_W-1:0]        peak_ff, peak_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic signed [SUM_W-1:0] start_ff, start_in;
   logic signed [SUM_W-1:0] end_ff, end_in;
   logic signed [V_W-1:0]   wave_last_ff;
   logic signed [SUM_W-1:0] mean_ff;
   logic signed [SUM_W-1:0] base_ff;
   logic signed [SUM_W-1:0] base_sum;

   logic                    div_start;
   logic                    mean_done;
   logic                    base_done;
   logic signed [SUM_W-1:0] mean_q;
   logic signed [SUM_W-1:0] base_q;

   logic                    out_free;
   logic                    load_sample;
   logic                    load_final;
   logic                    capture_q;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   assign {head_v, head_idx, head_flags} = head_data;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (!fifo_empty && out_free && head_flags.last) begin
               state_in = BK_LAUNCH;
            end
         end
         BK_LAUNCH: begin
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (mean_done) begin
               state_in = BK_FIN;
            end
         end
         BK_FIN: begin
            if (out_free) begin
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      pop         = 1'b0;
      load_sample = 1'b0;
      load_final  = 1'b0;
      div_start   = 1'b0;
      capture_q   = 1'b0;
      unique case (state_ff)
         BK_RUN: begin
            if (!fifo_empty && out_free) begin
               pop         = 1'b1;
               load_sample = !head_flags.last;
            end
         end
         BK_LAUNCH: begin
            div_start = 1'b1;
         end
         BK_DIV: begin
            capture_q = mean_done;
         end
         BK_FIN: begin
            load_final = out_free;
         end
         default: begin
         end
      endcase
   end

   // Running statistics; cleared when the summary is loaded into the result register.
   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      peak_in  = peak_ff;
      total_in = total_ff;
      start_in = start_ff;
      end_in   = end_ff;
      if (pop) begin
         if (head_v < min_ff) begin
            min_in = head_v;
         end
         if (head_v >= max_ff) begin
            max_in  = head_v;
            peak_in = head_idx;
         end
         total_in = total_ff + SUM_W'(head_v);
         if (head_flags.in_start) begin
            start_in = start_ff + SUM_W'(head_v);
         end
         if (head_flags.in_end) begin
            end_in = end_ff + SUM_W'(head_v);
         end
      end
      if (load_final) begin
         min_in   = MIN_RST;
         max_in   = MAX_RST;
         peak_in  = '0;
         total_in = '0;
         start_in = '0;
         end_in   = '0;
      end
   end

   // An early peak means the start window holds the pulse, so use the end window.
   assign base_sum = (32'(peak_ff) < 32'(guard_samples)) ? end_ff : start_ff;

   wfe_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (NW)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (n_eff),
      .done     (mean_done),
      .quotient (mean_q)
   );

   wfe_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (NW)
   ) u_base_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (base_sum),
      .divisor  (b_eff),
      .done     (base_done),
      .quotient (base_q)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (load_sample) begin
         rsp_data_in         = '0;
         rsp_data_in.wave_mv = OUT_W'(head_v);
         rsp_valid_in        = 1'b1;
      end else if (load_final) begin
         rsp_data_in.wave_mv         = OUT_W'(wave_last_ff);
         rsp_data_in.waveform_end    = 1'b1;
         rsp_data_in.min_mv          = OUT_W'(min_ff);
         rsp_data_in.max_mv          = OUT_W'(max_ff);
         rsp_data_in.peak_to_peak_mv = sat32(64'(max_ff) - 64'(min_ff));
         rsp_data_in.mean_mv         = sat32(64'(mean_ff));
         rsp_data_in.peak_index      = PEAK_W'(peak_ff);
         rsp_data_in.baseline_mv     = sat32(64'(base_ff));
         rsp_data_in.max_above_base  = sat32(64'(max_ff) - 64'(base_ff));
         rsp_data_in.min_above_base  = sat32(64'(min_ff) - 64'(base_ff));
         rsp_valid_in                = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         rsp_valid_ff <= 1'b0;
         min_ff       <= MIN_RST;
         max_ff       <= MAX_RST;
         peak_ff      <= '0;
         total_ff     <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         peak_ff      <= peak_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (pop && head_flags.last) begin
         wave_last_ff <= head_v;
      end
      if (capture_q && base_done) begin
         mean_ff <= mean_q;
         base_ff <= base_q;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.wave_mv         = rsp_data_ff.wave_mv;
   assign rsp_chan.waveform_end    = rsp_data_ff.waveform_end;
   assign rsp_chan.min_mv          = rsp_data_ff.min_mv;
   assign rsp_chan.max_mv          = rsp_data_ff.max_mv;
   assign rsp_chan.peak_to_peak_mv = rsp_data_ff.peak_to_peak_mv;
   assign rsp_chan.mean_mv         = rsp_data_ff.mean_mv;
   assign rsp_chan.peak_index      = rsp_data_ff.peak_index;
   assign rsp_chan.baseline_mv     = rsp_data_ff.baseline_mv;
   assign rsp_chan.max_above_base  = rsp_data_ff.max_above_base;
   assign rsp_chan.min_above_base  = rsp_data_ff.min_above_base;

endmodule

`default_nettype wire

>>> hw/rtl/waveform_feature_extractor.sv
// Top level of the waveform feature extractor: register file, front end, queue, back end.
// Depends on wfe_pkg, wfe_channels, wfe_fifo, wfe_divider, wfe_front and wfe_back.
//
// Usage: ADC codes of one waveform enter on req_chan, one code per transfer. Every code
// produces exactly one transfer on rsp_chan carrying the converted sample in Q15.16 mV.
// The transfer for the last code of a waveform also carries waveform_end and the summary
// (min, max, peak-to-peak, mean, peak index, baseline and max/min above the baseline).
// An accepted code passes the front-end stage register and the queue into the result
// register. Ordinary samples sustain one transfer per cycle while rsp_chan.ready stays
// high. The last sample of a waveform runs two radix-2 dividers in parallel (mean and
// baseline), one quotient bit per cycle over the width of the sum register, before the
// summary is loaded into the result register. Meanwhile the front end keeps taking codes
// into the two-entry queue and stops only when that queue and its own input stage are
// full. Registers are written through csr_we, csr_index and csr_wdata and must only
// change between transfers while nothing is in flight.
// Synchronous reset restores the register defaults, empties the queue, drops any pending
// result and starts a fresh waveform. When the receiver holds rsp_chan.ready low, the
// result register holds its contents, the back end stops draining the queue, and the
// front end stops accepting once the queue and its own stage are full.
`default_nettype none

module waveform_feature_extractor import wfe_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int ADC_BITS    = ADC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wfe_req_if.sink                    req_chan,
   wfe_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int V_W    = value_width(ADC_BITS);
   localparam int IDX_W  = index_width(MAX_SAMPLES);
   localparam int NW     = count_width(MAX_SAMPLES);
   localparam int ITEM_W = V_W + IDX_W + $bits(item_flags_type);

   logic [MV_W-1:0]   mv_per_code_ff, mv_per_code_in;
   logic              neg_pol_ff, neg_pol_in;
   logic [CFG_W-1:0]  num_samples_ff, num_samples_in;
   logic [CFG_W-1:0]  baseline_ff, baseline_in;
   logic [CFG_W-1:0]  guard_ff, guard_in;

   logic [CFG_W-1:0]  n_raw;
   logic [CFG_W-1:0]  b_raw;
   logic [NW-1:0]     n_eff;
   logic [NW-1:0]     b_eff;

   logic              push;
   logic [ITEM_W-1:0] push_data;
   logic              fifo_full;
   logic              pop;
   logic [ITEM_W-1:0] head_data;
   logic              fifo_empty;

   // Register file: write-only, one register per index, unknown indexes are ignored.
   always_comb begin
      mv_per_code_in = mv_per_code_ff;
      neg_pol_in     = neg_pol_ff;
      num_samples_in = num_samples_ff;
      baseline_in    = baseline_ff;
      guard_in       = guard_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MV_PER_CODE: mv_per_code_in = csr_wdata[MV_W-1:0];
            CSR_NEG_POL:     neg_pol_in     = csr_wdata[0];
            CSR_NUM_SAMPLES: num_samples_in = csr_wdata[CFG_W-1:0];
            CSR_BASELINE:    baseline_in    = csr_wdata[CFG_W-1:0];
            CSR_GUARD:       guard_in       = csr_wdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_per_code_ff <= MV_PER_CODE_RST;
         neg_pol_ff     <= NEG_POL_RST;
         num_samples_ff <= NUM_SAMPLES_RST;
         baseline_ff    <= BASELINE_RST;
         guard_ff       <= GUARD_RST;
      end else begin
         mv_per_code_ff <= mv_per_code_in;
         neg_pol_ff     <= neg_pol_in;
         num_samples_ff <= num_samples_in;
         baseline_ff    <= baseline_in;
         guard_ff       <= guard_in;
      end
   end

   // A zero length counts as one sample. The waveform length is capped at MAX_SAMPLES
   // and the window length at the waveform length.
   assign n_raw = (num_samples_ff == '0) ? CFG_W'(1) : num_samples_ff;
   assign b_raw = (baseline_ff == '0) ? CFG_W'(1) : baseline_ff;
   assign n_eff = (32'(n_raw) > 32'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(n_raw);
   assign b_eff = (32'(b_raw) > 32'(n_eff)) ? n_eff : NW'(b_raw);

   wfe_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .ADC_BITS    (ADC_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_chan          (req_chan),
      .mv_per_code       (mv_per_code_ff),
      .negative_polarity (neg_pol_ff),
      .n_eff             (n_eff),
      .b_eff             (b_eff),
      .fifo_full         (fifo_full),
      .push              (push),
      .push_data         (push_data)
   );

   wfe_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (fifo_empty)
   );

   wfe_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .ADC_BITS    (ADC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_data     (head_data),
      .fifo_empty    (fifo_empty),
      .pop           (pop),
      .n_eff         (n_eff),
      .b_eff         (b_eff),
      .guard_samples (guard_ff),
      .rsp_chan      (rsp_chan)
   );

endmodule

`default_nettype wire
